@@ rtl/pslc_pkg.sv @@
// ----------------------------------------------------------------------------
// pslc_pkg: shared definitions for the servo pattern slew controller
// Widths, mode and register codes, reset values and the result record.
// ----------------------------------------------------------------------------
package pslc_pkg;

    // Width of the saturating debounce and sweep ages
    localparam int AGE_BITS  = 12;
    localparam int AGE_CMP_W = (AGE_BITS > 12) ? AGE_BITS : 12;

    localparam int ANGLE_W   = 8;
    localparam int MODE_W    = 2;
    localparam int BUTTON_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int PHASE_W   = 11;
    localparam int LOOP_W    = 8;

    localparam logic [MODE_W-1:0] MODE_REST    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VIBRATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd2;

    localparam logic [BUTTON_W-1:0] BTN_NONE = 2'd0;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIBE_HALF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIBE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIBE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HIGH = 3'd7;

    localparam logic [ANGLE_W-1:0] REST_ANGLE = 8'd90;

    localparam logic [11:0]        RST_DEBOUNCE   = 12'd150;
    localparam logic [7:0]         RST_LOOP       = 8'd10;
    localparam logic [9:0]         RST_VIBE_HALF  = 10'd150;
    localparam logic [11:0]        RST_SWEEP_STEP = 12'd50;
    localparam logic [ANGLE_W-1:0] RST_VIBE_LOW   = 8'd30;
    localparam logic [ANGLE_W-1:0] RST_VIBE_HIGH  = 8'd150;
    localparam logic [ANGLE_W-1:0] RST_SWEEP_LOW  = 8'd70;
    localparam logic [ANGLE_W-1:0] RST_SWEEP_HIGH = 8'd110;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [MODE_W-1:0]  mode;
        logic               updated;
    } result_t;

endpackage

@@ rtl/pslc_core.sv @@
// ----------------------------------------------------------------------------
// pslc_core: tick processing for the servo pattern slew controller
// Holds configuration and controller state; computes one result per tick.
// ----------------------------------------------------------------------------
module pslc_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pslc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pslc_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             take,
    input  logic [pslc_pkg::BUTTON_W-1:0]    button,
    output pslc_pkg::result_t                result
);

    localparam logic [pslc_pkg::AGE_BITS-1:0] AGE_MAX = '1;

    // Configuration registers
    logic [11:0]                      debounce_ms_reg;
    logic [7:0]                       loop_period_reg;
    logic [9:0]                       vibe_half_reg;
    logic [11:0]                      sweep_step_reg;
    logic [pslc_pkg::ANGLE_W-1:0]     vibe_low_reg;
    logic [pslc_pkg::ANGLE_W-1:0]     vibe_high_reg;
    logic [pslc_pkg::ANGLE_W-1:0]     sweep_low_reg;
    logic [pslc_pkg::ANGLE_W-1:0]     sweep_high_reg;

    // Controller state
    logic [pslc_pkg::MODE_W-1:0]      mode_reg,         mode_next;
    logic [pslc_pkg::ANGLE_W-1:0]     angle_reg,        angle_next;
    logic [pslc_pkg::ANGLE_W-1:0]     target_reg,       target_next;
    logic                             sweep_up_reg,     sweep_up_next;
    logic [pslc_pkg::AGE_BITS-1:0]    debounce_age_reg, debounce_age_next;
    logic [pslc_pkg::AGE_BITS-1:0]    sweep_age_reg,    sweep_age_next;
    logic [pslc_pkg::PHASE_W-1:0]     vibe_phase_reg,   vibe_phase_next;
    logic [pslc_pkg::LOOP_W-1:0]      loop_count_reg,   loop_count_next;

    logic                             run;
    logic                             event_ok;
    logic                             sweep_due;
    logic [pslc_pkg::ANGLE_W-1:0]     target_step;
    logic [pslc_pkg::PHASE_W-1:0]     full_period;
    logic [pslc_pkg::PHASE_W:0]       phase_inc;
    logic [pslc_pkg::LOOP_W:0]        loop_inc;
    logic [pslc_pkg::AGE_BITS-1:0]    age_d_sat;
    logic [pslc_pkg::AGE_BITS-1:0]    age_s_sat;

    assign run      = (loop_count_reg == '0);
    assign event_ok = (button != pslc_pkg::BTN_NONE) &&
                      (pslc_pkg::AGE_CMP_W'(debounce_age_reg) >=
                       pslc_pkg::AGE_CMP_W'(debounce_ms_reg));
    assign sweep_due = (pslc_pkg::AGE_CMP_W'(sweep_age_reg) >=
                        pslc_pkg::AGE_CMP_W'(sweep_step_reg));
    assign target_step = sweep_up_reg ? (target_reg + 8'd1) : (target_reg - 8'd1);

    assign full_period = {vibe_half_reg, 1'b0};
    assign phase_inc   = {1'b0, vibe_phase_reg} + 12'd1;
    assign loop_inc    = {1'b0, loop_count_reg} + 9'd1;
    assign age_d_sat   = (debounce_age_reg == AGE_MAX) ? AGE_MAX : debounce_age_reg + 1'b1;
    assign age_s_sat   = (sweep_age_reg == AGE_MAX) ? AGE_MAX : sweep_age_reg + 1'b1;

    always_comb
    begin
        mode_next         = mode_reg;
        target_next       = target_reg;
        sweep_up_next     = sweep_up_reg;
        angle_next        = angle_reg;
        debounce_age_next = age_d_sat;
        sweep_age_next    = age_s_sat;

        // Accept the button event, restart debounce
        if (event_ok)
        begin
            mode_next         = pslc_pkg::MODE_W'(button - 2'd1);
            debounce_age_next = pslc_pkg::AGE_BITS'(1);
        end

        if (run)
        begin
            case (mode_next)
                pslc_pkg::MODE_REST:
                begin
                    target_next = pslc_pkg::REST_ANGLE;
                end
                pslc_pkg::MODE_VIBRATE:
                begin
                    target_next = ({1'b0, vibe_phase_reg} < {2'b00, vibe_half_reg}) ?
                                  vibe_low_reg : vibe_high_reg;
                end
                default:
                begin
                    if (sweep_due)
                    begin
                        // Age restarts at zero then advances this tick
                        sweep_age_next = pslc_pkg::AGE_BITS'(1);
                        target_next    = target_step;
                        if (target_step >= sweep_high_reg)
                        begin
                            sweep_up_next = 1'b0;
                        end
                        else if (target_step <= sweep_low_reg)
                        begin
                            sweep_up_next = 1'b1;
                        end
                    end
                end
            endcase

            if (angle_reg < target_next)
            begin
                angle_next = angle_reg + 8'd1;
            end
            else if (angle_reg > target_next)
            begin
                angle_next = angle_reg - 8'd1;
            end
        end

        vibe_phase_next = (phase_inc >= {1'b0, full_period}) ?
                          '0 : phase_inc[pslc_pkg::PHASE_W-1:0];
        loop_count_next = (loop_inc >= {1'b0, loop_period_reg}) ?
                          '0 : loop_inc[pslc_pkg::LOOP_W-1:0];
    end

    assign result.angle   = angle_next;
    assign result.mode    = mode_next;
    assign result.updated = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= pslc_pkg::MODE_REST;
            angle_reg        <= pslc_pkg::REST_ANGLE;
            target_reg       <= pslc_pkg::REST_ANGLE;
            sweep_up_reg     <= 1'b1;
            debounce_age_reg <= '0;
            sweep_age_reg    <= '0;
            vibe_phase_reg   <= '0;
            loop_count_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg         <= mode_next;
            angle_reg        <= angle_next;
            target_reg       <= target_next;
            sweep_up_reg     <= sweep_up_next;
            debounce_age_reg <= debounce_age_next;
            sweep_age_reg    <= sweep_age_next;
            vibe_phase_reg   <= vibe_phase_next;
            loop_count_reg   <= loop_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= pslc_pkg::RST_DEBOUNCE;
            loop_period_reg <= pslc_pkg::RST_LOOP;
            vibe_half_reg   <= pslc_pkg::RST_VIBE_HALF;
            sweep_step_reg  <= pslc_pkg::RST_SWEEP_STEP;
            vibe_low_reg    <= pslc_pkg::RST_VIBE_LOW;
            vibe_high_reg   <= pslc_pkg::RST_VIBE_HIGH;
            sweep_low_reg   <= pslc_pkg::RST_SWEEP_LOW;
            sweep_high_reg  <= pslc_pkg::RST_SWEEP_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pslc_pkg::REG_DEBOUNCE:   debounce_ms_reg <= cfg_data;
                pslc_pkg::REG_LOOP:       loop_period_reg <= cfg_data[7:0];
                pslc_pkg::REG_VIBE_HALF:  vibe_half_reg   <= cfg_data[9:0];
                pslc_pkg::REG_SWEEP_STEP: sweep_step_reg  <= cfg_data;
                pslc_pkg::REG_VIBE_LOW:   vibe_low_reg    <= cfg_data[7:0];
                pslc_pkg::REG_VIBE_HIGH:  vibe_high_reg   <= cfg_data[7:0];
                pslc_pkg::REG_SWEEP_LOW:  sweep_low_reg   <= cfg_data[7:0];
                pslc_pkg::REG_SWEEP_HIGH: sweep_high_reg  <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

endmodule

@@ rtl/pslc_obuf.sv @@
// ----------------------------------------------------------------------------
// pslc_obuf: two-entry result buffer
// Output register plus skid register; stall toward the core is registered.
// ----------------------------------------------------------------------------
module pslc_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pslc_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output pslc_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    pslc_pkg::result_t out_data_reg;
    pslc_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid entry into the output register
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

@@ rtl/servo_pattern_slew_controller_top.sv @@
// ----------------------------------------------------------------------------
// servo_pattern_slew_controller_top: servo pattern slew controller
// Output: each result is registered in the output or the skid register.
// Throughput: one tick transaction per cycle unless in_stall is high; the
// core state update is a single pass of counters and compares, and a
// two-entry result buffer absorbs output stalls.
// Reset: asynchronous active low; configuration returns to defaults, state
// to rest mode at 90 degrees, result buffer empty.
// ----------------------------------------------------------------------------
module servo_pattern_slew_controller_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pslc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pslc_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pslc_pkg::BUTTON_W-1:0]    button,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pslc_pkg::ANGLE_W-1:0]     angle,
    output logic [pslc_pkg::MODE_W-1:0]      mode,
    output logic                             updated
);

    logic              take;
    logic              buf_full;
    pslc_pkg::result_t core_result;
    pslc_pkg::result_t out_result;

    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    pslc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .button    (button),
        .result    (core_result)
    );

    pslc_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign angle   = out_result.angle;
    assign mode    = out_result.mode;
    assign updated = out_result.updated;

endmodule
